### rtl/core/rv32im_execute_stage_macros.svh
// assertion macros for the rv32im execute stage
// included by the top level only; no other dependencies
`ifndef RV32IM_EXECUTE_STAGE_MACROS_SVH
`define RV32IM_EXECUTE_STAGE_MACROS_SVH
`ifndef SYNTH
`define RVX_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("rvx assertion failed");
`define RVX_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("rvx assertion failed");
`else
`define RVX_ASSERT(lbl, clk, rstn, prop)
`define RVX_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/core/rv32ex_pkg.sv
// shared constants, opcode codes, types and helpers for the execute stage
// no dependencies
`default_nettype none
package rv32ex_pkg;
    // data memory size in bytes, a power of two
    localparam int MemBytes = 4096;
    localparam int MemAw    = $clog2(MemBytes);
    localparam int InW      = 56;
    localparam int OutW     = 80;

    localparam logic [5:0] OP_LW = 6'd0, OP_LB = 6'd1, OP_LH = 6'd2, OP_LBU = 6'd3,
        OP_LHU = 6'd4, OP_SB = 6'd5, OP_SH = 6'd6, OP_SW = 6'd7, OP_ADDI = 6'd8,
        OP_SLTI = 6'd9, OP_SLTIU = 6'd10, OP_ANDI = 6'd11, OP_ORI = 6'd12,
        OP_XORI = 6'd13, OP_SLLI = 6'd14, OP_SRLI = 6'd15, OP_SRAI = 6'd16,
        OP_ADD = 6'd17, OP_SUB = 6'd18, OP_SLT = 6'd19, OP_SLTU = 6'd20,
        OP_AND = 6'd21, OP_OR = 6'd22, OP_XOR = 6'd23, OP_SLL = 6'd24,
        OP_SRL = 6'd25, OP_SRA = 6'd26, OP_LUI = 6'd27, OP_AUIPC = 6'd28,
        OP_BEQ = 6'd29, OP_BNE = 6'd30, OP_BLT = 6'd31, OP_BGE = 6'd32,
        OP_BLTU = 6'd33, OP_BGEU = 6'd34, OP_JAL = 6'd35, OP_JALR = 6'd36,
        OP_MUL = 6'd37, OP_MULH = 6'd38, OP_MULHSU = 6'd39, OP_MULHU = 6'd40,
        OP_DIV = 6'd41, OP_DIVU = 6'd42, OP_REM = 6'd43, OP_REMU = 6'd44,
        OP_EBREAK = 6'd45, OP_ECALL = 6'd46, OP_FENCE = 6'd47;

    localparam logic [2:0] CL_ALU = 3'd0, CL_LOAD = 3'd1, CL_STORE = 3'd2,
        CL_MUL = 3'd3, CL_DIV = 3'd4;

    localparam logic CFG_START_PC = 1'b0;
    localparam logic CFG_RET_ADDR = 1'b1;

    typedef struct packed {
        logic accept;
        logic exec;
        logic mul_fin;
        logic div_step;
        logic div_fin;
        logic ld_take;
        logic st_write;
        logic wb;
    } t_cmd;

    typedef struct packed {
        logic [2:0] cls;
        logic       mem_last;
        logic       div_last;
        logic       out_free;
    } t_stat;

    function automatic logic [2:0] op_class(input logic [5:0] op);
        logic [2:0] c;
        case (op) inside
            [OP_LW:OP_LHU]:    c = CL_LOAD;
            [OP_SB:OP_SW]:     c = CL_STORE;
            [OP_MUL:OP_MULHU]: c = CL_MUL;
            [OP_DIV:OP_REMU]:  c = CL_DIV;
            default:           c = CL_ALU;
        endcase
        return c;
    endfunction

    // index of the last byte of an access
    function automatic logic [1:0] mem_last_idx(input logic [5:0] op);
        logic [1:0] n;
        case (op) inside
            OP_LW, OP_SW:         n = 2'd3;
            OP_LH, OP_LHU, OP_SH: n = 2'd1;
            default:              n = 2'd0;
        endcase
        return n;
    endfunction
endpackage
`default_nettype wire

### rtl/core/rv32im_execute_stage.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   one decoded instruction
// m_axis    out  m_axis_tvalid/m_axis_tready   one step result
// cfg       in   i_cfg_we                      start pc / return address
// alu, branch, jump and system ops go from execute to write back, multiply passes a finish
// state, divide and remainder step the shared divider (one quotient bit per cycle) and then finish,
// a load reads and takes each byte in turn and a store writes each byte (one memory byte port)
// the output register lets the next item in while a result still waits
// reset clears registers, pc, halt flag and control; data memory is not cleared
// top level of the execute stage; depends on rv32ex_pkg, rv32ex_ctrl, rv32ex_dpath
`default_nettype none
`include "rv32im_execute_stage_macros.svh"
module rv32im_execute_stage import rv32ex_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    // opcode[5:0], dest_index[10:6], first_source[15:11], second_source[20:16],
    // immediate[52:21]
    input  wire logic [InW-1:0]  s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    // next_pc[31:0], reg_write[32], written_index[37:33], written_value[69:38],
    // halted[70], done_res[71], misaligned_target[72]
    output logic [OutW-1:0]      m_axis_tdata,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic [31:0]     i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    rv32ex_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rv32ex_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    `RVX_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    `RVX_ASSERT(a_no_x0_write, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[37:33] != 5'd0))
    `RVX_ASSERT(a_halt_done, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tdata[70]) |-> m_axis_tdata[71])
endmodule
`default_nettype wire

### rtl/core/rv32ex_ctrl.sv
// sequencer for the execute stage: accept, execute, multi-cycle units, write back
// depends on rv32ex_pkg
`default_nettype none
module rv32ex_ctrl import rv32ex_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0, S_EXEC = 4'd1, S_MUL = 4'd2, S_DIV = 4'd3,
        S_DFIN = 4'd4, S_LDRD = 4'd5, S_LDWT = 4'd6, S_ST = 4'd7, S_WB = 4'd8;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_stat.cls)
                    CL_LOAD:  n_state = S_LDRD;
                    CL_STORE: n_state = S_ST;
                    CL_MUL:   n_state = S_MUL;
                    CL_DIV:   n_state = S_DIV;
                    default:  n_state = S_WB;
                endcase
            end
            S_MUL: begin
                o_cmd.mul_fin = 1'b1;
                n_state       = S_WB;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_DFIN;
            end
            S_DFIN: begin
                o_cmd.div_fin = 1'b1;
                n_state       = S_WB;
            end
            S_LDRD: n_state = S_LDWT;
            S_LDWT: begin
                o_cmd.ld_take = 1'b1;
                n_state       = i_stat.mem_last ? S_WB : S_LDRD;
            end
            S_ST: begin
                o_cmd.st_write = 1'b1;
                if (i_stat.mem_last) n_state = S_WB;
            end
            S_WB: begin
                if (i_stat.out_free) begin
                    o_cmd.wb = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule
`default_nettype wire

### rtl/core/rv32ex_dpath.sv
// datapath: register file, pc, alu, multiplier, divider, byte memory, result register
// depends on rv32ex_pkg
`default_nettype none
module rv32ex_dpath import rv32ex_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cmd            i_cmd,
    output t_stat                o_stat,
    input  wire logic [InW-1:0]  i_in_data,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic [31:0]     i_cfg_data,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic [OutW-1:0]      o_out_data
);
    logic [31:0] rf [32];
    logic [31:0] r_rfv;
    logic [7:0]  dmem [MemBytes];
    logic [7:0]  r_mrd;

    logic [5:0]  r_op;
    logic [4:0]  r_rd;
    logic [31:0] r_imm, r_a, r_b, r_pc, r_ret, r_val, r_npc, r_addr;
    logic        r_halt, r_wr, r_mis;
    logic [1:0]  r_cnt;
    logic [63:0] r_prod;
    logic [31:0] r_dq, r_drem, r_dvs;
    logic [4:0]  r_dcnt;
    logic        r_negq, r_negr, r_dz;

    logic        r_ov, r_owr, r_ohalt, r_odone, r_omis;
    logic [31:0] r_onpc, r_oval;
    logic [4:0]  r_oidx;

    logic [5:0]  in_op;
    logic [4:0]  in_rd, in_rs1, in_rs2;
    logic [31:0] in_imm;
    assign in_op  = i_in_data[5:0];
    assign in_rd  = i_in_data[10:6];
    assign in_rs1 = i_in_data[15:11];
    assign in_rs2 = i_in_data[20:16];
    assign in_imm = i_in_data[52:21];

    // execute-cycle results
    logic [31:0] n_val, n_npc, ea, tgt;
    logic        n_wr, take, jump;
    logic [4:0]  sh;
    logic [32:0] ma, mb;
    logic        sgn_div;
    logic signed [65:0] prod;

    always_comb begin
        n_val = '0;
        n_wr  = 1'b1;
        take  = 1'b0;
        jump  = 1'b0;
        ea    = r_a + r_imm;
        tgt   = r_pc + r_imm;
        sh    = (op_class(r_op) == CL_ALU && r_op <= OP_SRAI) ? r_imm[4:0] : r_b[4:0];
        case (r_op)
            OP_ADDI:  n_val = r_a + r_imm;
            OP_SLTI:  n_val = {31'd0, $signed(r_a) < $signed(r_imm)};
            OP_SLTIU: n_val = {31'd0, r_a < r_imm};
            OP_ANDI:  n_val = r_a & r_imm;
            OP_ORI:   n_val = r_a | r_imm;
            OP_XORI:  n_val = r_a ^ r_imm;
            OP_ADD:   n_val = r_a + r_b;
            OP_SUB:   n_val = r_a - r_b;
            OP_SLT:   n_val = {31'd0, $signed(r_a) < $signed(r_b)};
            OP_SLTU:  n_val = {31'd0, r_a < r_b};
            OP_AND:   n_val = r_a & r_b;
            OP_OR:    n_val = r_a | r_b;
            OP_XOR:   n_val = r_a ^ r_b;
            OP_SLLI, OP_SLL: n_val = r_a << sh;
            OP_SRLI, OP_SRL: n_val = r_a >> sh;
            OP_SRAI, OP_SRA: n_val = $unsigned($signed(r_a) >>> sh);
            OP_LUI:   n_val = r_imm;
            OP_AUIPC: n_val = r_pc + r_imm;
            OP_BEQ:   begin n_wr = 1'b0; take = (r_a == r_b); end
            OP_BNE:   begin n_wr = 1'b0; take = (r_a != r_b); end
            OP_BLT:   begin n_wr = 1'b0; take = $signed(r_a) < $signed(r_b); end
            OP_BGE:   begin n_wr = 1'b0; take = $signed(r_a) >= $signed(r_b); end
            OP_BLTU:  begin n_wr = 1'b0; take = r_a < r_b; end
            OP_BGEU:  begin n_wr = 1'b0; take = r_a >= r_b; end
            OP_JAL:   begin n_val = r_pc + 32'd4; jump = 1'b1; end
            OP_JALR:  begin
                n_val = r_pc + 32'd4;
                jump  = 1'b1;
                tgt   = {ea[31:1], 1'b0};
            end
            OP_SB, OP_SH, OP_SW, OP_EBREAK, OP_ECALL, OP_FENCE: n_wr = 1'b0;
            default: n_wr = (op_class(r_op) != CL_ALU);
        endcase
        // a jump target is aligned when its low bits match those of the pc
        n_npc = r_pc + 32'd4;
        if ((take || jump) && tgt[1:0] == r_pc[1:0]) n_npc = tgt;
        else if (take || jump)                       n_npc = r_pc;

        ma   = (r_op == OP_MULH || r_op == OP_MULHSU) ? {r_a[31], r_a} : {1'b0, r_a};
        mb   = (r_op == OP_MULH) ? {r_b[31], r_b} : {1'b0, r_b};
        prod = $signed(ma) * $signed(mb);
        sgn_div = (r_op == OP_DIV || r_op == OP_REM);
    end

    // one restoring step of the divider
    logic [32:0] rem_sh, diff;
    assign rem_sh = {r_drem, r_dq[31]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    logic [MemAw-1:0] maddr;
    assign maddr = r_addr[MemAw-1:0] + MemAw'(r_cnt);

    logic [31:0] wb_val;
    logic        wb_halt;
    always_comb begin
        case (r_op)
            OP_LB:   wb_val = {{24{r_val[7]}}, r_val[7:0]};
            OP_LH:   wb_val = {{16{r_val[15]}}, r_val[15:0]};
            default: wb_val = r_val;
        endcase
        wb_halt = r_halt || r_op == OP_EBREAK || r_op == OP_ECALL;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= in_op;
            r_rd  <= in_rd;
            r_imm <= in_imm;
            r_a   <= r_rfv[in_rs1] ? rf[in_rs1] : 32'd0;
            r_b   <= r_rfv[in_rs2] ? rf[in_rs2] : 32'd0;
        end
        if (i_cmd.exec) begin
            r_val  <= n_val;
            r_wr   <= n_wr && (r_rd != 5'd0);
            r_npc  <= n_npc;
            r_mis  <= (take || jump) && tgt[1:0] != r_pc[1:0];
            r_addr <= ea;
            r_cnt  <= 2'd0;
            r_prod <= prod[63:0];
            r_dq   <= (sgn_div && r_a[31]) ? -r_a : r_a;
            r_dvs  <= (sgn_div && r_b[31]) ? -r_b : r_b;
            r_drem <= '0;
            r_dcnt <= '0;
            r_negq <= sgn_div && (r_a[31] != r_b[31]);
            r_negr <= sgn_div && r_a[31];
            r_dz   <= (r_b == 32'd0);
        end
        if (i_cmd.mul_fin)
            r_val <= (r_op == OP_MUL) ? r_prod[31:0] : r_prod[63:32];
        if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 5'd1;
            r_dq   <= {r_dq[30:0], !diff[32]};
            r_drem <= diff[32] ? rem_sh[31:0] : diff[31:0];
        end
        if (i_cmd.div_fin) begin
            if (r_op == OP_DIV || r_op == OP_DIVU)
                r_val <= r_dz ? 32'hffff_ffff : (r_negq ? -r_dq : r_dq);
            else
                r_val <= r_negr ? -r_drem : r_drem;
        end
        if (i_cmd.ld_take) begin
            r_val <= r_val | ({24'd0, r_mrd} << {r_cnt, 3'b000});
            r_cnt <= r_cnt + 2'd1;
        end
        if (i_cmd.st_write) r_cnt <= r_cnt + 2'd1;
        if (i_cmd.wb && r_wr) rf[r_rd] <= wb_val;
        if (i_cmd.wb) begin
            r_onpc  <= r_npc;
            r_owr   <= r_wr;
            r_oidx  <= r_wr ? r_rd : 5'd0;
            r_oval  <= r_wr ? wb_val : 32'd0;
            r_ohalt <= wb_halt;
            r_odone <= wb_halt || (r_npc == r_ret);
            r_omis  <= r_mis;
        end
    end

    // byte memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.st_write) dmem[maddr] <= 8'(r_b >> {r_cnt, 3'b000});
        r_mrd <= dmem[maddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rfv  <= '0;
            r_pc   <= '0;
            r_ret  <= 32'hffff_ffff;
            r_halt <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_START_PC) r_pc  <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_RET_ADDR) r_ret <= i_cfg_data;
            if (i_out_ready) r_ov <= 1'b0;
            if (i_cmd.wb) begin
                r_pc   <= r_npc;
                r_halt <= wb_halt;
                r_ov   <= 1'b1;
                if (r_wr) r_rfv[r_rd] <= 1'b1;
            end
        end
    end

    assign o_stat.cls      = op_class(r_op);
    assign o_stat.mem_last = (r_cnt == mem_last_idx(r_op));
    assign o_stat.div_last = (r_dcnt == 5'd31);
    assign o_stat.out_free = !r_ov || i_out_ready;

    assign o_out_valid = r_ov;
    assign o_out_data  = {7'd0, r_omis, r_odone, r_ohalt, r_oval, r_oidx, r_owr, r_onpc};
endmodule
`default_nettype wire

### sim/rv32im_execute_stage_tb.sv
// self-checking testbench for the rv32im execute stage: drives decoded instructions on
// the input stream, predicts every step result and checks each output transfer
// depends on rv32ex_pkg and rv32im_execute_stage
`default_nettype none
module rv32im_execute_stage_tb;
    import rv32ex_pkg::*;

    localparam int NumItems  = 1800;
    localparam int CycleLimit = 1000000;

    typedef struct {
        logic [5:0]  op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
    } instr_t;

    typedef struct {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  written_index;
        logic [31:0] written_value;
        logic        halted;
        logic        done_res;
        logic        misaligned_target;
    } retire_t;

    // architectural mirror of the stage plus the queue of steps still to retire
    class exec_scoreboard;
        logic [31:0] regs [32];
        logic [31:0] pc;
        logic [31:0] ret_addr;
        bit          halt;
        logic [7:0]  mem [MemBytes];
        bit          mem_valid [MemBytes];
        retire_t     pending_retire [$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (mem_valid[i]) mem_valid[i] = 0;
            pc = '0;
            ret_addr = 32'hffff_ffff;
            halt = 0;
            errors = 0;
        endfunction

        function void write_cfg(logic idx, logic [31:0] v);
            if (idx == CFG_START_PC) pc = v;
            else ret_addr = v;
        endfunction

        function logic [31:0] load_bytes(logic [31:0] addr, int n);
            logic [31:0] v;
            logic [31:0] x;
            v = '0;
            for (int i = 0; i < n; i++) begin
                x = addr + i;
                v[8*i +: 8] = mem[x[MemAw-1:0]];
            end
            return v;
        endfunction

        function void store_bytes(logic [31:0] addr, logic [31:0] v, int n);
            logic [31:0] x;
            for (int i = 0; i < n; i++) begin
                x = addr + i;
                mem[x[MemAw-1:0]] = v[8*i +: 8];
                mem_valid[x[MemAw-1:0]] = 1;
            end
        endfunction

        function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b, bit want_rem);
            logic [31:0] ma, mb, q, r;
            if (b == 0) return want_rem ? a : 32'hffff_ffff;
            if (a == 32'h8000_0000 && b == 32'hffff_ffff)
                return want_rem ? 32'h0 : 32'h8000_0000;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            r = ma % mb;
            if (want_rem) return a[31] ? -r : r;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        // execute one accepted instruction and queue its expected step result
        function void execute(instr_t it);
            logic [31:0] a, b, val, npc, off, addr;
            logic [63:0] sa, sb, prod;
            bit wr, take, jump, mis;
            retire_t r;
            a = regs[it.rs1];
            b = regs[it.rs2];
            addr = a + it.imm;
            npc = pc + 4;
            val = '0;
            wr = 0; take = 0; jump = 0; mis = 0;
            off = '0;
            sa = {{32{a[31]}}, a};
            sb = {{32{b[31]}}, b};
            case (it.op)
                OP_LW:     begin val = load_bytes(addr, 4); wr = 1; end
                OP_LB:     begin val = load_bytes(addr, 1); val = {{24{val[7]}}, val[7:0]}; wr = 1; end
                OP_LH:     begin val = load_bytes(addr, 2); val = {{16{val[15]}}, val[15:0]}; wr = 1; end
                OP_LBU:    begin val = load_bytes(addr, 1); wr = 1; end
                OP_LHU:    begin val = load_bytes(addr, 2); wr = 1; end
                OP_SB:     store_bytes(addr, b, 1);
                OP_SH:     store_bytes(addr, b, 2);
                OP_SW:     store_bytes(addr, b, 4);
                OP_ADDI:   begin val = addr; wr = 1; end
                OP_SLTI:   begin val = ($signed(a) < $signed(it.imm)) ? 1 : 0; wr = 1; end
                OP_SLTIU:  begin val = (a < it.imm) ? 1 : 0; wr = 1; end
                OP_ANDI:   begin val = a & it.imm; wr = 1; end
                OP_ORI:    begin val = a | it.imm; wr = 1; end
                OP_XORI:   begin val = a ^ it.imm; wr = 1; end
                OP_SLLI:   begin val = a << it.imm[4:0]; wr = 1; end
                OP_SRLI:   begin val = a >> it.imm[4:0]; wr = 1; end
                OP_SRAI:   begin val = $signed(a) >>> it.imm[4:0]; wr = 1; end
                OP_ADD:    begin val = a + b; wr = 1; end
                OP_SUB:    begin val = a - b; wr = 1; end
                OP_SLT:    begin val = ($signed(a) < $signed(b)) ? 1 : 0; wr = 1; end
                OP_SLTU:   begin val = (a < b) ? 1 : 0; wr = 1; end
                OP_AND:    begin val = a & b; wr = 1; end
                OP_OR:     begin val = a | b; wr = 1; end
                OP_XOR:    begin val = a ^ b; wr = 1; end
                OP_SLL:    begin val = a << b[4:0]; wr = 1; end
                OP_SRL:    begin val = a >> b[4:0]; wr = 1; end
                OP_SRA:    begin val = $signed(a) >>> b[4:0]; wr = 1; end
                OP_LUI:    begin val = it.imm; wr = 1; end
                OP_AUIPC:  begin val = pc + it.imm; wr = 1; end
                OP_BEQ:    take = (a == b);
                OP_BNE:    take = (a != b);
                OP_BLT:    take = ($signed(a) < $signed(b));
                OP_BGE:    take = ($signed(a) >= $signed(b));
                OP_BLTU:   take = (a < b);
                OP_BGEU:   take = (a >= b);
                OP_JAL:    begin val = pc + 4; wr = 1; jump = 1; off = it.imm; end
                OP_JALR:   begin
                    val = pc + 4; wr = 1; jump = 1;
                    off = {addr[31:1], 1'b0} - pc;
                end
                OP_MUL:    begin val = a * b; wr = 1; end
                OP_MULH:   begin prod = sa * sb; val = prod[63:32]; wr = 1; end
                OP_MULHSU: begin prod = sa * {32'h0, b}; val = prod[63:32]; wr = 1; end
                OP_MULHU:  begin prod = {32'h0, a} * {32'h0, b}; val = prod[63:32]; wr = 1; end
                OP_DIV:    begin val = sdiv(a, b, 0); wr = 1; end
                OP_DIVU:   begin val = (b == 0) ? 32'hffff_ffff : a / b; wr = 1; end
                OP_REM:    begin val = sdiv(a, b, 1); wr = 1; end
                OP_REMU:   begin val = (b == 0) ? a : a % b; wr = 1; end
                OP_EBREAK, OP_ECALL: halt = 1;
                default: ;
            endcase
            if (take) begin
                jump = 1;
                off = it.imm;
            end
            if (jump) begin
                if (off[1:0] == 2'b00) npc = pc + off;
                else begin
                    npc = pc;
                    mis = 1;
                end
            end
            if (it.rd == 0) wr = 0;
            if (wr) regs[it.rd] = val;
            pc = npc;
            r.next_pc = npc;
            r.reg_write = wr;
            r.written_index = wr ? it.rd : 5'd0;
            r.written_value = wr ? val : 32'd0;
            r.halted = halt;
            r.done_res = halt || (npc == ret_addr);
            r.misaligned_target = mis;
            pending_retire.push_back(r);
        endfunction

        function void check_result(logic [OutW-1:0] d);
            retire_t e;
            if (pending_retire.size() == 0) begin
                $error("step result with no instruction outstanding: %h", d);
                errors++;
                return;
            end
            e = pending_retire.pop_front();
            if (d[31:0] !== e.next_pc) begin
                $error("next_pc exp %h got %h", e.next_pc, d[31:0]); errors++;
            end
            if (d[32] !== e.reg_write) begin
                $error("reg_write exp %h got %h", e.reg_write, d[32]); errors++;
            end
            if (d[37:33] !== e.written_index) begin
                $error("written_index exp %h got %h", e.written_index, d[37:33]); errors++;
            end
            if (d[69:38] !== e.written_value) begin
                $error("written_value exp %h got %h", e.written_value, d[69:38]); errors++;
            end
            if (d[70] !== e.halted) begin
                $error("halted exp %h got %h", e.halted, d[70]); errors++;
            end
            if (d[71] !== e.done_res) begin
                $error("done_res exp %h got %h", e.done_res, d[71]); errors++;
            end
            if (d[72] !== e.misaligned_target) begin
                $error("misaligned_target exp %h got %h", e.misaligned_target, d[72]); errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [InW-1:0]    s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OutW-1:0]   m_axis_tdata;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = CFG_START_PC;
    logic [31:0]       i_cfg_data = '0;

    exec_scoreboard sb = new();
    int  send_idle_pct = 29;
    int  recv_idle_pct = 75;
    int  hold_cycles = 0;
    int  cycle_count = 0;
    bit  halts_allowed = 0;

    rv32im_execute_stage i_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: check every output transfer, stall at random or for a long hold
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(4095)) - 2048);
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return 32'h8000_0000;
            default: return 32'h7fff_ffff;
        endcase
    endfunction

    function automatic int access_bytes(logic [5:0] op);
        case (op)
            OP_LW, OP_SW: return 4;
            OP_LH, OP_LHU, OP_SH: return 2;
            default: return 1;
        endcase
    endfunction

    // random instruction, built from the current mirrored state so loads only hit written bytes
    function automatic instr_t random_instr();
        instr_t it;
        logic [31:0] a, full, x;
        int n, r;
        bit ok;
        it.rd = 5'($urandom());
        it.rs1 = 5'($urandom());
        it.rs2 = 5'($urandom());
        it.imm = pick_imm();
        r = $urandom_range(99);
        if (r < 25) it.op = 6'($urandom_range(OP_SW, OP_LW));
        else if (r < 30) it.op = 6'($urandom_range(63, 48));
        else if (r < 38) it.op = OP_LUI;
        else begin
            it.op = 6'($urandom_range(OP_FENCE, OP_ADDI));
            if ((it.op == OP_EBREAK || it.op == OP_ECALL) && !halts_allowed) it.op = OP_FENCE;
        end
        a = sb.regs[it.rs1];
        n = access_bytes(it.op);
        if (it.op <= OP_LHU) begin
            ok = 0;
            for (int t = 0; t < 16 && !ok; t++) begin
                full = {20'($urandom_range(32'hfffff)), 4'h0, 8'($urandom())};
                ok = 1;
                for (int i = 0; i < n; i++) begin
                    x = full + i;
                    if (!sb.mem_valid[x[MemAw-1:0]]) ok = 0;
                end
            end
            if (!ok) it.op = (n == 4) ? OP_SW : (n == 2) ? OP_SH : OP_SB;
            it.imm = full - a;
        end
        if (it.op >= OP_SB && it.op <= OP_SW && $urandom_range(3) != 0) begin
            full = {20'($urandom_range(32'hfffff)), 4'h0, 8'($urandom())};
            it.imm = full - a;
        end
        if ((it.op >= OP_BEQ && it.op <= OP_JAL) && $urandom_range(3) != 0)
            it.imm = 32'($signed($urandom_range(255)) - 128) << 2;
        if (it.op == OP_JALR && $urandom_range(2) != 0)
            it.imm = sb.pc - a + (32'($signed($urandom_range(63)) - 32) << 1) + $urandom_range(1);
        return it;
    endfunction

    function automatic instr_t mk(logic [5:0] op, logic [4:0] rd, logic [4:0] rs1,
                                  logic [4:0] rs2, logic [31:0] imm);
        instr_t it;
        it.op = op; it.rd = rd; it.rs1 = rs1; it.rs2 = rs2; it.imm = imm;
        return it;
    endfunction

    task automatic send_instr(instr_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b0, it.imm, it.rs2, it.rs1, it.rd, it.op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.execute(it);
    endtask

    // drain every outstanding step before touching the configuration
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_retire.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.write_cfg(idx, v);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        instr_t directed [$];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed = '{
            mk(OP_LUI, 1, 0, 0, 32'h8000_0000), mk(OP_ADDI, 2, 0, 0, 32'hffff_ffff),
            mk(OP_DIV, 3, 1, 2, 0), mk(OP_REM, 4, 1, 2, 0),
            mk(OP_DIV, 5, 1, 0, 0), mk(OP_DIVU, 6, 2, 0, 0),
            mk(OP_REM, 7, 2, 0, 0), mk(OP_REMU, 8, 1, 0, 0),
            mk(OP_MULH, 9, 1, 2, 0), mk(OP_MULHSU, 10, 2, 2, 0),
            mk(OP_MULHU, 11, 2, 2, 0), mk(OP_MUL, 12, 2, 2, 0),
            // word store straddling the top of memory, then loads that wrap round
            mk(OP_SW, 0, 0, 1, 32'h0000_0ffe), mk(OP_LW, 13, 0, 0, 32'hffff_fffe),
            mk(OP_LB, 14, 0, 0, 32'h0000_0fff), mk(OP_LH, 15, 0, 0, 32'h0000_0fff),
            mk(OP_LBU, 16, 0, 0, 32'h0000_0fff), mk(OP_LHU, 17, 0, 0, 32'h0000_1fff),
            mk(OP_SRA, 18, 1, 2, 0), mk(OP_SRAI, 19, 1, 0, 32'h1f),
            mk(OP_JAL, 20, 0, 0, 32'h2), mk(OP_JALR, 2, 2, 0, 32'h9),
            mk(OP_BEQ, 0, 0, 0, 32'h8), mk(OP_BNE, 0, 1, 0, 32'h6),
            mk(OP_FENCE, 31, 31, 31, 32'hffff_ffff), mk(6'd63, 31, 1, 2, 32'h1234_5678)
        };

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 75 : 0;
            recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 29 : 0;
            if (ph > 0) wait_idle();
            case (ph)
                0: begin
                    cfg_write(CFG_START_PC, 32'h0);
                    cfg_write(CFG_RET_ADDR, 32'h40);
                end
                1: begin
                    cfg_write(CFG_START_PC, 32'hffff_ffff);
                    cfg_write(CFG_START_PC, 32'hffff_fff0);
                    cfg_write(CFG_RET_ADDR, 32'h0);
                end
                default: begin
                    cfg_write(CFG_START_PC, 32'h0000_1000);
                    cfg_write(CFG_RET_ADDR, 32'hffff_ffff);
                    hold_cycles = 400;
                end
            endcase
            if (ph == 0) foreach (directed[i]) send_instr(directed[i]);
            for (int i = 0; i < NumItems / 3; i++) begin
                // halting is sticky, so it only comes near the very end
                halts_allowed = (ph == 2) && (i > NumItems / 3 - 80);
                send_instr(random_instr());
            end
        end
        s_axis_tvalid <= 1'b0;
        while (sb.pending_retire.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_retire.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
